/* hdl/mrq_pkg.sv */
package mrq_pkg;

  // Command codes carried by the cmd field
  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_NEXT   = 1'b1;

  // The create that brings the running total to this count starts the tick timer
  localparam int unsigned TICK_START_COUNT = 2;

  // Width of the saturating create counter
  localparam int unsigned TOTAL_W = 7;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POOL_FULL = 2'd1,
    STATUS_NO_READY  = 2'd2
  } status_t;

endpackage

/* hdl/mrq_ram.sv */
module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/mrq_free_find.sv */
module mrq_free_find #(
  parameter int SLOTS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [SLOTS-1:0]         busy,
  output logic                     found,
  output logic [$clog2(SLOTS)-1:0] idx
);

  localparam int SW = $clog2(SLOTS);

  logic          found_next;
  logic [SW-1:0] idx_next;

  // Lowest free slot; scan from the top so the lowest index wins
  always_comb begin
    found_next = 1'b0;
    idx_next   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found_next = 1'b1;
        idx_next   = SW'(i);
      end
    end
  end

  // Registered result, reflecting the busy bits of the previous cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      found <= found_next;
    end
    idx <= idx_next;
  end

endmodule

/* hdl/multilevel_ready_queue_scheduler_top.sv */
// Multilevel ready-queue thread scheduler.
// Input channel (in_valid / in_stall) takes one command word: cmd, level_sel,
// active_slot, active_is_null. A create (cmd 0) takes the lowest free slot and
// appends it to its level's FIFO if it has room; a next (cmd 1) requeues a
// non-null active slot likewise, then pops the head of the highest-priority non-empty queue.
// Output channel (out_valid / out_stall) returns one result word per command:
// status, chosen_slot, start_ticking.
// Steps: a create's result word is loaded in the create step after acceptance; a
// next looks up the level at acceptance, then writes the requeue, then pops and
// reads the queue memory, then loads the result (from the pop step if no queue
// is ready). One command is in flight at a time: in_stall stays high until the
// command has finished its steps, so no new command is taken before that.
// The block accepts the next command while the previous result is still held
// in the output register. If the receiver stalls, a create commits no state
// until the result register frees; a next finishes its queue updates and holds
// the picked slot in its last step until then.
// Reset: after rst drops the block spends one cycle writing the idle thread
// (slot 0) into the idle queue and the level table, with in_stall high.
module multilevel_ready_queue_scheduler_top #(
  parameter int POOL_SLOTS = 8,
  parameter int NUM_LEVELS = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [2:0] level_sel,
  input  logic [2:0] active_slot,
  input  logic       active_is_null,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [2:0] chosen_slot,
  output logic       start_ticking
);

  localparam int SW    = $clog2(POOL_SLOTS);
  localparam int LW    = $clog2(NUM_LEVELS);
  localparam int CW    = $clog2(POOL_SLOTS + 1);
  localparam int PW    = CW + 1;
  localparam int QD    = NUM_LEVELS * POOL_SLOTS;
  localparam int QA    = $clog2(QD);
  localparam int TW    = mrq_pkg::TOTAL_W;
  localparam logic [LW-1:0] IDLE_LVL = LW'(NUM_LEVELS - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CREATE,
    ST_REQUEUE,
    ST_POP,
    ST_READ
  } state_t;

  state_t state;

  // Latched command word
  logic          c_cmd;
  logic [LW-1:0] c_lvl;
  logic [2:0]    c_act;
  logic          c_null;

  // Scheduler state in flops
  logic [POOL_SLOTS-1:0] slot_busy;
  logic [SW-1:0]         queue_head  [NUM_LEVELS];
  logic [CW-1:0]         queue_count [NUM_LEVELS];
  logic [TW-1:0]         created_total;

  // Output register
  mrq_pkg::status_t out_status;
  logic [2:0]       out_slot;
  logic             out_tick;

  logic out_free;
  logic accept;
  logic [LW-1:0] sel_lvl;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Out-of-range levels fall to the idle level
  assign sel_lvl = ({1'b0, level_sel} >= 4'(NUM_LEVELS)) ? IDLE_LVL : LW'(level_sel);

  // Free slot search
  logic          free_found;
  logic [SW-1:0] free_idx;

  mrq_free_find #(.SLOTS(POOL_SLOTS)) u_free (
    .clk   (clk),
    .rst   (rst),
    .busy  (slot_busy),
    .found (free_found),
    .idx   (free_idx)
  );

  // Per-slot level table
  logic          lv_we;
  logic [SW-1:0] lv_waddr;
  logic [LW-1:0] lv_wdata;
  logic [LW-1:0] lv_rdata;

  mrq_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_level_ram (
    .clk   (clk),
    .we    (lv_we),
    .waddr (lv_waddr),
    .wdata (lv_wdata),
    .re    (accept),
    .raddr (SW'(active_slot)),
    .rdata (lv_rdata)
  );

  // Ready queue store, one region of POOL_SLOTS entries per level
  logic          q_we;
  logic [QA-1:0] q_waddr;
  logic [SW-1:0] q_wdata;
  logic          q_re;
  logic [QA-1:0] q_raddr;
  logic [SW-1:0] q_rdata;

  mrq_ram #(.WIDTH(SW), .DEPTH(QD)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Requeue decode
  logic [SW-1:0] act_idx;
  logic          req_ok;
  logic [LW-1:0] req_lvl;

  assign act_idx = SW'(c_act);
  assign req_ok  = !c_null && (7'(c_act) < 7'(POOL_SLOTS));
  assign req_lvl = slot_busy[act_idx] ? lv_rdata : '0;

  // Push target: level of create or of requeue
  logic [LW-1:0] push_lvl;
  logic [SW-1:0] push_slot;
  logic          push_room;
  logic [PW-1:0] push_sum;
  logic [SW-1:0] push_pos;

  assign push_lvl  = (state == ST_CREATE) ? c_lvl : req_lvl;
  assign push_slot = (state == ST_CREATE) ? free_idx : act_idx;
  assign push_room = queue_count[push_lvl] < CW'(POOL_SLOTS);
  assign push_sum  = PW'(queue_head[push_lvl]) + PW'(queue_count[push_lvl]);
  assign push_pos  = (push_sum >= PW'(POOL_SLOTS)) ? SW'(push_sum - PW'(POOL_SLOTS))
                                                    : SW'(push_sum);

  // Highest-priority non-empty queue
  logic          pop_found;
  logic [LW-1:0] pop_lvl;
  logic [SW-1:0] pop_head_inc;

  always_comb begin
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (queue_count[i] != '0) begin
        pop_found = 1'b1;
        pop_lvl   = LW'(i);
      end
    end
  end

  assign pop_head_inc = (queue_head[pop_lvl] == SW'(POOL_SLOTS - 1)) ? '0
                                                                     : queue_head[pop_lvl] + 1'b1;

  // Create commit
  logic          create_go;
  logic [TW-1:0] total_next;

  assign create_go  = (state == ST_CREATE) && out_free && free_found;
  assign total_next = (created_total == '1) ? created_total : created_total + 1'b1;

  // Result register load: a finishing step with room in the output register
  logic out_load;

  assign out_load = out_free && ((state == ST_CREATE) || (state == ST_READ) ||
                                 ((state == ST_POP) && !pop_found));

  // Memory write and read control
  always_comb begin
    lv_we    = 1'b0;
    lv_waddr = '0;
    lv_wdata = IDLE_LVL;
    q_we     = 1'b0;
    q_waddr  = QA'(NUM_LEVELS - 1) * QA'(POOL_SLOTS);
    q_wdata  = '0;
    q_re     = 1'b0;
    q_raddr  = QA'(pop_lvl) * QA'(POOL_SLOTS) + QA'(queue_head[pop_lvl]);
    case (state)
      ST_INIT: begin
        lv_we = 1'b1;
        q_we  = 1'b1;
      end
      ST_CREATE: begin
        lv_we    = create_go;
        lv_waddr = free_idx;
        lv_wdata = c_lvl;
        q_we     = create_go && push_room;
        q_waddr  = QA'(push_lvl) * QA'(POOL_SLOTS) + QA'(push_pos);
        q_wdata  = push_slot;
      end
      ST_REQUEUE: begin
        q_we    = req_ok && push_room;
        q_waddr = QA'(push_lvl) * QA'(POOL_SLOTS) + QA'(push_pos);
        q_wdata = push_slot;
      end
      ST_POP: begin
        q_re = pop_found;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, scheduler state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      out_valid     <= 1'b0;
      slot_busy     <= POOL_SLOTS'(1);
      created_total <= TW'(1);
      for (int i = 0; i < NUM_LEVELS; i++) begin
        queue_head[i]  <= '0;
        queue_count[i] <= (i == NUM_LEVELS - 1) ? CW'(1) : '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            c_cmd  <= cmd;
            c_lvl  <= sel_lvl;
            c_act  <= active_slot;
            c_null <= active_is_null;
            state  <= (cmd == mrq_pkg::CMD_CREATE) ? ST_CREATE : ST_REQUEUE;
          end
        end
        ST_CREATE: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (free_found) begin
              slot_busy[free_idx] <= 1'b1;
              created_total       <= total_next;
              if (push_room) begin
                queue_count[push_lvl] <= queue_count[push_lvl] + 1'b1;
              end
              out_status <= mrq_pkg::STATUS_OK;
              out_slot   <= 3'(free_idx);
              out_tick   <= (total_next == TW'(mrq_pkg::TICK_START_COUNT));
            end else begin
              out_status <= mrq_pkg::STATUS_POOL_FULL;
              out_slot   <= '0;
              out_tick   <= 1'b0;
            end
          end
        end
        ST_REQUEUE: begin
          if (req_ok && push_room) begin
            queue_count[push_lvl] <= queue_count[push_lvl] + 1'b1;
          end
          state <= ST_POP;
        end
        ST_POP: begin
          if (pop_found) begin
            queue_head[pop_lvl]  <= pop_head_inc;
            queue_count[pop_lvl] <= queue_count[pop_lvl] - 1'b1;
            state                <= ST_READ;
          end else if (out_free) begin
            out_status <= mrq_pkg::STATUS_NO_READY;
            out_slot   <= '0;
            out_tick   <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_status <= mrq_pkg::STATUS_OK;
            out_slot   <= 3'(q_rdata);
            out_tick   <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign status        = out_status;
  assign chosen_slot   = out_slot;
  assign start_ticking = out_tick;

  // A latched next command never reaches the create step
  a_cmd_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CREATE) |-> (c_cmd == mrq_pkg::CMD_CREATE))
    else $error("create step entered for a next command");

  // Results only appear out of a finishing step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_CREATE || state == ST_POP || state == ST_READ))
    else $error("result word appeared outside a finishing step");

  // Tick start only on a successful create
  a_tick_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && start_ticking) |-> (status == mrq_pkg::STATUS_OK))
    else $error("start_ticking raised with an error status");

  // The idle thread's slot never becomes free and the create count never wraps to zero
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    slot_busy[0] && (created_total != '0))
    else $error("slot 0 freed or create count wrapped");

endmodule

/* tb/sv/tb_multilevel_ready_queue_scheduler_top.sv */
`timescale 1ns / 100ps

module tb_multilevel_ready_queue_scheduler_top;

  localparam int POOL_SLOTS   = 8;
  localparam int NUM_LEVELS   = 5;
  localparam int IDLE_LEVEL   = NUM_LEVELS - 1;
  localparam int CREATED_MAX  = (1 << mrq_pkg::TOTAL_W) - 1;
  localparam int RANDOM_WORDS = 1400;
  localparam int IDLE_PCT     = 37;
  // window of cycles in which neither side idles
  localparam int CALM_START   = 3000;
  localparam int CALM_END     = 4500;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic       cmd;
    logic [2:0] level;
    logic [2:0] active;
    logic       is_null;
  } sched_cmd_t;

  typedef struct packed {
    mrq_pkg::status_t status;
    logic [2:0]       slot;
    logic             tick;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd = mrq_pkg::CMD_CREATE;
  logic [2:0] level_sel = 3'd0;
  logic [2:0] active_slot = 3'd0;
  logic       active_is_null = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [2:0] chosen_slot;
  logic       start_ticking;

  multilevel_ready_queue_scheduler_top #(
    .POOL_SLOTS(POOL_SLOTS),
    .NUM_LEVELS(NUM_LEVELS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .level_sel(level_sel),
    .active_slot(active_slot),
    .active_is_null(active_is_null),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .chosen_slot(chosen_slot),
    .start_ticking(start_ticking)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sched_cmd_t    pending_words[$];
  sched_result_t expected_results[$];
  int            cycle_count = 0;
  int            error_count = 0;
  int            create_count = 0;
  int            next_count = 0;
  int            pool_full_count = 0;
  int            no_ready_count = 0;
  int            dropped_count = 0;

  // shadow scheduler state
  logic                        slot_busy  [POOL_SLOTS];
  logic [2:0]                  slot_level [POOL_SLOTS];
  logic [2:0]                  ready_fifo [NUM_LEVELS][POOL_SLOTS];
  logic [2:0]                  ready_head [NUM_LEVELS];
  logic [3:0]                  ready_count[NUM_LEVELS];
  logic [mrq_pkg::TOTAL_W-1:0] created_total;

  initial begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_level[i] = 3'd0;
    end
    for (int l = 0; l < NUM_LEVELS; l++) begin
      ready_head[l]  = 3'd0;
      ready_count[l] = 4'd0;
      for (int i = 0; i < POOL_SLOTS; i++) ready_fifo[l][i] = 3'd0;
    end
    // idle thread lives in slot 0 on the idle queue
    slot_busy[0]  = 1'b1;
    slot_level[0] = 3'(IDLE_LEVEL);
    ready_count[IDLE_LEVEL] = 4'd1;
    created_total = mrq_pkg::TOTAL_W'(1);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic bit take_break();
    if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // append to a level's FIFO; a full FIFO drops the slot
  function automatic void enqueue_ready(int lvl, logic [2:0] slot);
    int pos;
    if (ready_count[lvl] >= POOL_SLOTS) begin
      dropped_count++;
    end else begin
      pos = (int'(ready_head[lvl]) + int'(ready_count[lvl])) % POOL_SLOTS;
      ready_fifo[lvl][pos] = slot;
      ready_count[lvl]++;
    end
  endfunction

  // advance the shadow scheduler by one command word, return its result
  function automatic sched_result_t schedule_word(sched_cmd_t w);
    sched_result_t r;
    int            lvl;
    int            i;
    bit            found;
    r.status = mrq_pkg::STATUS_OK;
    r.slot   = 3'd0;
    r.tick   = 1'b0;
    found    = 1'b0;
    if (w.cmd == mrq_pkg::CMD_CREATE) begin
      create_count++;
      lvl = (w.level >= NUM_LEVELS) ? IDLE_LEVEL : int'(w.level);
      for (i = 0; i < POOL_SLOTS; i++) begin
        if (!found && !slot_busy[i]) begin
          found  = 1'b1;
          r.slot = 3'(i);
        end
      end
      if (!found) begin
        r.status = mrq_pkg::STATUS_POOL_FULL;
        pool_full_count++;
      end else begin
        slot_busy[r.slot]  = 1'b1;
        slot_level[r.slot] = 3'(lvl);
        if (created_total < CREATED_MAX) created_total++;
        enqueue_ready(lvl, r.slot);
        r.tick = (created_total == mrq_pkg::TICK_START_COUNT);
      end
    end else begin
      next_count++;
      // requeue the running thread, even if its slot is free
      if (!w.is_null && w.active < POOL_SLOTS)
        enqueue_ready(int'(slot_level[w.active]), w.active);
      for (i = 0; i < NUM_LEVELS; i++) begin
        if (!found && ready_count[i] != 0) begin
          found  = 1'b1;
          r.slot = ready_fifo[i][ready_head[i]];
          ready_head[i]  = 3'((int'(ready_head[i]) + 1) % POOL_SLOTS);
          ready_count[i] = ready_count[i] - 4'd1;
        end
      end
      if (!found) begin
        r.status = mrq_pkg::STATUS_NO_READY;
        no_ready_count++;
      end
    end
    return r;
  endfunction

  // input driver: predicts each accepted word, then loads the next one
  always @(posedge clk) begin : drive_proc
    sched_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid)
        expected_results.push_back(schedule_word({cmd, level_sel, active_slot, active_is_null}));
      if (pending_words.size() != 0 && !take_break()) begin
        nxt = pending_words.pop_front();
        in_valid       <= 1'b1;
        cmd            <= nxt.cmd;
        level_sel      <= nxt.level;
        active_slot    <= nxt.active;
        active_is_null <= nxt.is_null;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk) begin : check_proc
    sched_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d chosen_slot %0d start_ticking %0d",
                 status, chosen_slot, start_ticking);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            error_count++;
          end
          if (chosen_slot !== want.slot) begin
            $error("chosen_slot: expected %0d, actual %0d", want.slot, chosen_slot);
            error_count++;
          end
          if (start_ticking !== want.tick) begin
            $error("start_ticking: expected %0d, actual %0d", want.tick, start_ticking);
            error_count++;
          end
        end
      end
      out_stall <= take_break();
    end
  end

  task automatic add_create(input logic [2:0] lvl);
    sched_cmd_t w;
    w.cmd     = mrq_pkg::CMD_CREATE;
    w.level   = lvl;
    w.active  = 3'($urandom_range(7));
    w.is_null = 1'($urandom_range(1));
    pending_words.push_back(w);
  endtask

  task automatic add_next(input logic [2:0] act, input logic nul);
    sched_cmd_t w;
    w.cmd     = mrq_pkg::CMD_NEXT;
    w.level   = 3'($urandom_range(7));
    w.active  = act;
    w.is_null = nul;
    pending_words.push_back(w);
  endtask

  initial begin
    // fill slots 1..6, level select above the idle level saturates
    add_create(3'd0);               // second thread: tick starts
    add_create(3'd1);
    add_create(3'd2);
    add_create(3'd3);
    add_create(3'd7);
    add_create(3'd5);
    // slot 7 still free: requeued at level 0
    add_next(3'd7, 1'b0);
    add_create(3'd6);               // last free slot
    add_create(3'd0);               // pool exhausted
    add_create(3'd4);
    // push the idle thread until the idle FIFO holds a full pool
    repeat (4) add_next(3'd0, 1'b0);
    add_next(3'd5, 1'b0);           // idle FIFO full, requeue dropped
    add_next(3'd6, 1'b0);

    // random: mostly requeuing nexts, rare nulls so the queues stay populated
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(99) < 6)
        add_create(3'($urandom_range(7)));
      else
        add_next(3'($urandom_range(7)), $urandom_range(149) == 0);
    end
    // drain every queue (at most a full pool per level) to reach the empty case
    repeat (NUM_LEVELS * POOL_SLOTS + 4) add_next(3'($urandom_range(7)), 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d creates and %0d nexts through the scheduler", create_count, next_count);
    $display("  pool exhausted %0d, no ready thread %0d, dropped requeues %0d",
             pool_full_count, no_ready_count, dropped_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
hdl/mrq_pkg.sv
hdl/mrq_ram.sv
hdl/mrq_free_find.sv
hdl/multilevel_ready_queue_scheduler_top.sv
tb/sv/tb_multilevel_ready_queue_scheduler_top.sv
